>>> sv/cbpf_pkg.sv
// ----------------------------------------------------------------------------
// cbpf_pkg
// shared constants, types and weight function of the bezier path flattener
// ----------------------------------------------------------------------------
`default_nettype none

package cbpf_pkg;

  // number of trailing zero bits, used to split the step denominator
  function automatic int trailing_zeros(input longint v);
    int     n;
    longint t;
    n = 0;
    t = v;
    for (int i = 0; i < 63; i++) begin
      if (t != 0 && t[0] == 1'b0) begin
        t = t >>> 1;
        n++;
      end
    end
    return n;
  endfunction

  localparam int STEPS       = 24;
  localparam int COORD_WIDTH = 24;

  localparam int     K_W    = $clog2(STEPS + 1);
  localparam longint DEN    = longint'(STEPS) * STEPS * STEPS;
  localparam int     WGT_W  = $clog2(DEN + 1);
  localparam int     PROD_W = COORD_WIDTH + WGT_W + 1;
  localparam int     SUM_W  = PROD_W + 2;
  localparam int     U_W    = COORD_WIDTH + WGT_W;

  // denominator = 2^DEN_TZ * ODD, the odd part goes through a reciprocal
  localparam int     DEN_TZ  = trailing_zeros(DEN);
  localparam longint ODD     = DEN >>> DEN_TZ;
  localparam int     ODD_W   = $clog2(ODD);
  localparam int     M_W     = COORD_WIDTH + ODD_W;
  localparam int     REC_K   = COORD_WIDTH + 2 * ODD_W;
  localparam longint RECIP   = ((longint'(1) << REC_K) + ODD - 1) / ODD;
  localparam int     RECIP_W = REC_K - ODD_W + 1;
  localparam int     QP_W    = M_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  // half denominator for rounding plus offset that makes the sum non-negative
  localparam longint BIAS = DEN / 2 + (DEN << (COORD_WIDTH - 1));
  localparam logic signed [SUM_W-1:0] BIAS_S = SUM_W'(BIAS);

  localparam logic [K_W-1:0] LAST_K = K_W'(STEPS);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  localparam coord_t COORD_MAX = coord_t'((longint'(1) << (COORD_WIDTH - 1)) - 1);
  localparam coord_t COORD_MIN = coord_t'(longint'(1) << (COORD_WIDTH - 1));

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEG,
    ST_CLOSE
  } ctrl_state_t;

  typedef struct packed {
    logic           load_item;
    logic           load_close;
    logic           clear_path;
    logic           issue;
    logic [K_W-1:0] k;
    logic           last;
  } cmd_t;

  typedef struct packed {
    logic advance;
    logic load_ok;
    logic seen_any;
  } status_t;

  // bernstein weight j of step k, scaled by STEPS^3
  function automatic logic [WGT_W-1:0] bez_weight(input int j, input logic [K_W-1:0] k);
    longint kk;
    longint rr;
    longint w;
    kk = longint'(k);
    rr = STEPS - kk;
    case (j)
      0:       w = rr * rr * rr;
      1:       w = 3 * kk * rr * rr;
      2:       w = 3 * kk * kk * rr;
      default: w = kk * kk * kk;
    endcase
    return w[WGT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> sv/cbpf_ctrl.sv
// ----------------------------------------------------------------------------
// cbpf_ctrl
// sequencer: takes anchors, steps through segment points, closing segment
// ----------------------------------------------------------------------------
`default_nettype none

module cbpf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              end_of_path,
  output logic                   in_ready,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_data,
  output logic                   cfg_ready,
  input  wire cbpf_pkg::status_t status,
  output cbpf_pkg::cmd_t         cmd
);

  cbpf_pkg::ctrl_state_t        state, state_next;
  logic [cbpf_pkg::K_W-1:0]     k, k_next;
  logic                         close_pending, close_pending_next;
  logic                         path_closed;
  logic                         closing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= cbpf_pkg::ST_IDLE;
      k             <= '0;
      close_pending <= 1'b0;
      path_closed   <= 1'b0;
    end else begin
      state         <= state_next;
      k             <= k_next;
      close_pending <= close_pending_next;
      if (cfg_valid && cfg_ready) begin
        path_closed <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next         = state;
    k_next             = k;
    close_pending_next = close_pending;
    in_ready           = 1'b0;
    closing            = end_of_path && path_closed && status.seen_any;
    cmd                = '0;
    cmd.k              = k;
    cmd.last           = (k == cbpf_pkg::LAST_K) && !close_pending;
    unique case (state)
      cbpf_pkg::ST_IDLE: begin
        in_ready = status.load_ok;
        if (in_valid && status.load_ok) begin
          cmd.load_item  = 1'b1;
          cmd.clear_path = end_of_path && !closing;
          if (status.seen_any) begin
            state_next         = cbpf_pkg::ST_SEG;
            k_next             = '0;
            close_pending_next = closing;
          end
        end
      end
      cbpf_pkg::ST_SEG: begin
        cmd.issue = 1'b1;
        if (status.advance) begin
          if (k == cbpf_pkg::LAST_K) begin
            k_next     = '0;
            state_next = close_pending ? cbpf_pkg::ST_CLOSE : cbpf_pkg::ST_IDLE;
          end else begin
            k_next = k + cbpf_pkg::K_W'(1);
          end
        end
      end
      cbpf_pkg::ST_CLOSE: begin
        if (status.load_ok) begin
          cmd.load_close     = 1'b1;
          cmd.clear_path     = 1'b1;
          close_pending_next = 1'b0;
          k_next             = '0;
          state_next         = cbpf_pkg::ST_SEG;
        end
      end
      default: begin
        state_next = cbpf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/cbpf_datapath.sv
// ----------------------------------------------------------------------------
// cbpf_datapath
// path state, segment control points and the five-stage point pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module cbpf_datapath (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cbpf_pkg::cmd_t   cmd,
  output cbpf_pkg::status_t     status,
  input  wire cbpf_pkg::coord_t anchor_x,
  input  wire cbpf_pkg::coord_t anchor_y,
  input  wire cbpf_pkg::coord_t in_ctrl_x,
  input  wire cbpf_pkg::coord_t in_ctrl_y,
  input  wire cbpf_pkg::coord_t out_ctrl_x,
  input  wire cbpf_pkg::coord_t out_ctrl_y,
  input  wire logic             has_in_ctrl,
  input  wire logic             has_out_ctrl,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cbpf_pkg::coord_t      point_x,
  output cbpf_pkg::coord_t      point_y,
  output logic                  last_point
);

  cbpf_pkg::coord_t entry_x, entry_y, exit_x, exit_y;

  cbpf_pkg::coord_t prev_anchor_x, prev_anchor_y;
  cbpf_pkg::coord_t prev_exit_ctrl_x, prev_exit_ctrl_y;
  cbpf_pkg::coord_t first_anchor_x, first_anchor_y;
  cbpf_pkg::coord_t first_entry_ctrl_x, first_entry_ctrl_y;
  logic [1:0]       anchors_seen;

  cbpf_pkg::coord_t seg_x [4];
  cbpf_pkg::coord_t seg_y [4];

  logic adv;
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_last, s2_last, s3_last, s4_last;

  logic        [cbpf_pkg::WGT_W-1:0]  s1_w   [4];
  logic signed [cbpf_pkg::WGT_W:0]    wgt_s  [4];
  logic signed [cbpf_pkg::PROD_W-1:0] prod_x [4];
  logic signed [cbpf_pkg::PROD_W-1:0] prod_y [4];
  logic signed [cbpf_pkg::SUM_W-1:0]  sum_x, sum_y;
  logic        [cbpf_pkg::U_W-1:0]    u_x, u_y;
  logic        [cbpf_pkg::M_W-1:0]    m_x, m_y;
  logic        [cbpf_pkg::QP_W-1:0]   qp_x, qp_y;
  logic        [cbpf_pkg::COORD_WIDTH-1:0] q_x, q_y;
  cbpf_pkg::coord_t b_x, b_y, neg_y;

  // missing control points fall back to the anchor
  assign entry_x = has_in_ctrl  ? in_ctrl_x  : anchor_x;
  assign entry_y = has_in_ctrl  ? in_ctrl_y  : anchor_y;
  assign exit_x  = has_out_ctrl ? out_ctrl_x : anchor_x;
  assign exit_y  = has_out_ctrl ? out_ctrl_y : anchor_y;

  assign adv             = !out_valid || out_ready;
  assign status.advance  = adv;
  assign status.load_ok  = !s1_valid || adv;
  assign status.seen_any = (anchors_seen != 2'd0);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_path) begin
      prev_anchor_x      <= '0;
      prev_anchor_y      <= '0;
      prev_exit_ctrl_x   <= '0;
      prev_exit_ctrl_y   <= '0;
      first_anchor_x     <= '0;
      first_anchor_y     <= '0;
      first_entry_ctrl_x <= '0;
      first_entry_ctrl_y <= '0;
      anchors_seen       <= 2'd0;
    end else if (cmd.load_item) begin
      if (anchors_seen == 2'd0) begin
        first_anchor_x     <= anchor_x;
        first_anchor_y     <= anchor_y;
        first_entry_ctrl_x <= entry_x;
        first_entry_ctrl_y <= entry_y;
      end
      prev_anchor_x    <= anchor_x;
      prev_anchor_y    <= anchor_y;
      prev_exit_ctrl_x <= exit_x;
      prev_exit_ctrl_y <= exit_y;
      if (anchors_seen != 2'd2) begin
        anchors_seen <= anchors_seen + 2'd1;
      end
    end
  end

  // control points of the segment being stepped
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      seg_x[0] <= prev_anchor_x;
      seg_y[0] <= prev_anchor_y;
      seg_x[1] <= prev_exit_ctrl_x;
      seg_y[1] <= prev_exit_ctrl_y;
      seg_x[2] <= entry_x;
      seg_y[2] <= entry_y;
      seg_x[3] <= anchor_x;
      seg_y[3] <= anchor_y;
    end else if (cmd.load_close) begin
      seg_x[0] <= prev_anchor_x;
      seg_y[0] <= prev_anchor_y;
      seg_x[1] <= prev_exit_ctrl_x;
      seg_y[1] <= prev_exit_ctrl_y;
      seg_x[2] <= first_entry_ctrl_x;
      seg_y[2] <= first_entry_ctrl_y;
      seg_x[3] <= first_anchor_x;
      seg_y[3] <= first_anchor_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= cmd.issue;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      wgt_s[j] = $signed({1'b0, s1_w[j]});
    end
    sum_x = cbpf_pkg::SUM_W'(prod_x[0]) + cbpf_pkg::SUM_W'(prod_x[1])
          + cbpf_pkg::SUM_W'(prod_x[2]) + cbpf_pkg::SUM_W'(prod_x[3])
          + cbpf_pkg::BIAS_S;
    sum_y = cbpf_pkg::SUM_W'(prod_y[0]) + cbpf_pkg::SUM_W'(prod_y[1])
          + cbpf_pkg::SUM_W'(prod_y[2]) + cbpf_pkg::SUM_W'(prod_y[3])
          + cbpf_pkg::BIAS_S;
  end

  // power-of-two part of the denominator is a shift
  assign m_x = u_x[cbpf_pkg::DEN_TZ +: cbpf_pkg::M_W];
  assign m_y = u_y[cbpf_pkg::DEN_TZ +: cbpf_pkg::M_W];

  // quotient carries the offset in its top bit
  assign q_x   = qp_x[cbpf_pkg::REC_K +: cbpf_pkg::COORD_WIDTH];
  assign q_y   = qp_y[cbpf_pkg::REC_K +: cbpf_pkg::COORD_WIDTH];
  assign b_x   = {~q_x[cbpf_pkg::COORD_WIDTH-1], q_x[cbpf_pkg::COORD_WIDTH-2:0]};
  assign b_y   = {~q_y[cbpf_pkg::COORD_WIDTH-1], q_y[cbpf_pkg::COORD_WIDTH-2:0]};
  assign neg_y = (b_y == cbpf_pkg::COORD_MIN) ? cbpf_pkg::COORD_MAX : -b_y;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last <= cmd.last;
      for (int j = 0; j < 4; j++) begin
        s1_w[j] <= cbpf_pkg::bez_weight(j, cmd.k);
      end
      s2_last <= s1_last;
      for (int j = 0; j < 4; j++) begin
        prod_x[j] <= seg_x[j] * wgt_s[j];
        prod_y[j] <= seg_y[j] * wgt_s[j];
      end
      s3_last    <= s2_last;
      u_x        <= sum_x[cbpf_pkg::U_W-1:0];
      u_y        <= sum_y[cbpf_pkg::U_W-1:0];
      s4_last    <= s3_last;
      qp_x       <= m_x * cbpf_pkg::RECIP_V;
      qp_y       <= m_y * cbpf_pkg::RECIP_V;
      last_point <= s4_last;
      point_x    <= b_x;
      point_y    <= neg_y;
    end
  end

endmodule

`default_nettype wire

>>> sv/cubic_bezier_path_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_path_flattener
// flattens a path of cubic bezier anchors into uniformly stepped points
// ----------------------------------------------------------------------------
//
// channel   direction  handshake              payload
// in        input      in_valid / in_ready    anchor, control points, flags
// out       output     out_valid / out_ready  point_x, point_y, last_point
// cfg       input      cfg_valid / cfg_ready  cfg_data (path_closed)
//
// an anchor that opens a segment is taken in a transfer, then the step
// counter in the sequencer issues one point per cycle unless out stalls
// a final anchor of a closed path also steps the closing segment
// each point leaves through the point pipeline of the datapath
// reset is synchronous; a stall on out freezes the whole point pipeline
// the next anchor is taken while the last points still drain
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_path_flattener (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire cbpf_pkg::coord_t anchor_x,
  input  wire cbpf_pkg::coord_t anchor_y,
  input  wire cbpf_pkg::coord_t in_ctrl_x,
  input  wire cbpf_pkg::coord_t in_ctrl_y,
  input  wire cbpf_pkg::coord_t out_ctrl_x,
  input  wire cbpf_pkg::coord_t out_ctrl_y,
  input  wire logic             has_in_ctrl,
  input  wire logic             has_out_ctrl,
  input  wire logic             end_of_path,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output cbpf_pkg::coord_t      point_x,
  output cbpf_pkg::coord_t      point_y,
  output logic                  last_point,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_data
);

  // commands from the sequencer, status back from the datapath
  cbpf_pkg::cmd_t    cmd;
  cbpf_pkg::status_t status;

  // sequencer: owns path_closed and the step counter
  cbpf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .end_of_path (end_of_path),
    .in_ready    (in_ready),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .cfg_ready   (cfg_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // datapath: path state, weights, products, rounding divide, y negate
  cbpf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .anchor_x     (anchor_x),
    .anchor_y     (anchor_y),
    .in_ctrl_x    (in_ctrl_x),
    .in_ctrl_y    (in_ctrl_y),
    .out_ctrl_x   (out_ctrl_x),
    .out_ctrl_y   (out_ctrl_y),
    .has_in_ctrl  (has_in_ctrl),
    .has_out_ctrl (has_out_ctrl),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point)
  );

endmodule

`default_nettype wire

>>> sv/cbpf_checker.sv
// ----------------------------------------------------------------------------
// cbpf_checker
// port-level checks of the bezier path flattener, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cbpf_checker (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire cbpf_pkg::coord_t point_x,
  input wire cbpf_pkg::coord_t point_y,
  input wire logic             last_point
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(point_x) && $stable(point_y)
                                && $stable(last_point))
    else $error("result changed under stall");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // in_ready drops only after reset, after an input valid or while the output stalls
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(rst) || $past(in_valid) || (out_valid && !out_ready))
    else $error("in_ready dropped without cause");

endmodule

bind cubic_bezier_path_flattener cbpf_checker u_cbpf_checker (.*);

`default_nettype wire
